FILE: sv/cmt_pkg.sv
package cmt_pkg;

    localparam int MAX_MODES   = 64;
    localparam int DIMENSIONS  = 2;

    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 34;
    localparam int CLUSTER_W   = 6;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

    localparam int INDEX_W     = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int COUNT_W     = $clog2(MAX_MODES + 1);
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int SUM_W       = SQ_W + $clog2(DIMENSIONS);

    // One point or one stored mode, coordinate d in slice d
    typedef logic [DIMENSIONS-1:0][COORD_W-1:0] point_t;

    typedef logic [SQ_W-1:0] sq_t;

    // Tag of an entry travelling down the compare pipeline
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] idx;
    } lane_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RES_MATCH,
        RES_NEW,
        RES_FULL,
        RES_CLEAR
    } res_kind_t;

    // Index masked or zero extended to the width of the result field
    function automatic logic [CLUSTER_W-1:0] to_cluster(input logic [INDEX_W-1:0] idx);
        logic [INDEX_W+CLUSTER_W-1:0] wide;
        wide = {{CLUSTER_W{1'b0}}, idx};
        return wide[CLUSTER_W-1:0];
    endfunction

endpackage

FILE: sv/cmt_ifs.sv
interface cmt_point_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic signed [cmt_pkg::COORD_W-1:0] coord_0;
    logic signed [cmt_pkg::COORD_W-1:0] coord_1;

    modport source (output valid, mode, coord_0, coord_1, input ready);
    modport sink   (input valid, mode, coord_0, coord_1, output ready);
endinterface

interface cmt_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [cmt_pkg::COORD_W-1:0] mode_coord_0;
    logic signed [cmt_pkg::COORD_W-1:0] mode_coord_1;
    logic [cmt_pkg::CLUSTER_W-1:0]      cluster_index;
    logic                               new_cluster;
    logic                               table_full;

    modport source (output valid, mode_coord_0, mode_coord_1, cluster_index,
                    new_cluster, table_full, input ready);
    modport sink   (input valid, mode_coord_0, mode_coord_1, cluster_index,
                    new_cluster, table_full, output ready);
endinterface

interface cmt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cmt_pkg::RADIUS_W-1:0]  radius_squared;

    modport source (output valid, radius_squared, input ready);
    modport sink   (input valid, radius_squared, output ready);
endinterface

FILE: sv/cmt_ram.sv
module cmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/cmt_dist.sv
module cmt_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cmt_pkg::lane_t                    lane_in,
    input  cmt_pkg::point_t                   entry_in,
    input  cmt_pkg::point_t                   point,
    input  logic [cmt_pkg::RADIUS_W-1:0]      radius,
    output cmt_pkg::lane_t                    lane_out,
    output cmt_pkg::point_t                   entry_out,
    output logic                              match
);

    cmt_pkg::lane_t  lane_reg;
    cmt_pkg::point_t entry_reg;
    cmt_pkg::sq_t    sq_reg   [cmt_pkg::DIMENSIONS];
    cmt_pkg::sq_t    sq_next  [cmt_pkg::DIMENSIONS];

    logic signed [cmt_pkg::DIFF_W-1:0] diff [cmt_pkg::DIMENSIONS];
    logic signed [cmt_pkg::SQ_W-1:0]   prod [cmt_pkg::DIMENSIONS];
    logic [cmt_pkg::SUM_W-1:0]         sum;

    // One squarer per coordinate, registered before the sum
    always_comb
    begin
        for (int d = 0; d < cmt_pkg::DIMENSIONS; d++)
        begin
            diff[d]    = $signed({point[d][cmt_pkg::COORD_W-1], point[d]})
                       - $signed({entry_in[d][cmt_pkg::COORD_W-1], entry_in[d]});
            prod[d]    = diff[d] * diff[d];
            sq_next[d] = $unsigned(prod[d]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg.valid <= 1'b0;
            lane_reg.idx   <= '0;
        end
        else
        begin
            lane_reg <= lane_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_in;
        for (int d = 0; d < cmt_pkg::DIMENSIONS; d++)
        begin
            sq_reg[d] <= sq_next[d];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int d = 0; d < cmt_pkg::DIMENSIONS; d++)
        begin
            sum = sum + cmt_pkg::SUM_W'(sq_reg[d]);
        end
    end

    // A distance equal to the radius still counts as a match
    assign match     = lane_reg.valid && (sum <= cmt_pkg::SUM_W'(radius));
    assign lane_out  = lane_reg;
    assign entry_out = entry_reg;

endmodule

FILE: sv/cluster_mode_table.sv
// Leader-style cluster assignment over a table of up to MAX_MODES modes held in
// one synchronous RAM. An assign item walks the stored modes in index order, one
// RAM read per cycle into a two-stage squared-distance pipeline; the first mode
// within radius_squared is returned with its index. With no match the point is
// appended as a new mode, or flagged table_full when the table is full. The
// block returns to idle as the result is registered and then takes the next
// item. One item is worked on at a time; a new item is taken while the
// previous result waits in the output register. Write radius_squared only
// while the block is idle.
module cluster_mode_table (
    input  logic          clk,
    input  logic          rst_n,
    cmt_point_if.sink     point,
    cmt_result_if.source  result,
    cmt_cfg_if.sink       cfg
);

    cmt_pkg::state_t     state_reg, state_next;
    logic [cmt_pkg::RADIUS_W-1:0] radius_reg;
    logic [cmt_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [cmt_pkg::COUNT_W-1:0]  issue_reg, issue_next;
    cmt_pkg::lane_t      p1_reg, p1_next;

    cmt_pkg::point_t     pt_reg, pt_next;
    cmt_pkg::res_kind_t  kind_reg, kind_next;
    cmt_pkg::point_t     res_coord_reg, res_coord_next;
    logic [cmt_pkg::INDEX_W-1:0] res_idx_reg, res_idx_next;

    logic                out_valid_reg, out_valid_next;
    cmt_pkg::point_t     out_coord_reg, out_coord_next;
    logic [cmt_pkg::CLUSTER_W-1:0] out_idx_reg, out_idx_next;
    logic                out_new_reg, out_new_next;
    logic                out_full_reg, out_full_next;

    logic                accept;
    logic                issue;
    logic                scan_end;
    logic                out_free;
    logic                emit;
    logic                ram_we;
    logic                match;
    cmt_pkg::point_t     ram_rdata;
    cmt_pkg::lane_t      lane_in;
    cmt_pkg::lane_t      lane_out;
    cmt_pkg::point_t     entry_out;

    assign accept   = point.valid && point.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign scan_end = (issue_reg == count_reg) && !p1_reg.valid && !lane_out.valid;

    cmt_ram #(
        .WIDTH ($bits(cmt_pkg::point_t)),
        .DEPTH (cmt_pkg::MAX_MODES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[cmt_pkg::INDEX_W-1:0]),
        .wdata (pt_reg),
        .raddr (issue_reg[cmt_pkg::INDEX_W-1:0]),
        .rdata (ram_rdata)
    );

    cmt_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_in   (lane_in),
        .entry_in  (ram_rdata),
        .point     (pt_reg),
        .radius    (radius_reg),
        .lane_out  (lane_out),
        .entry_out (entry_out),
        .match     (match)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cmt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = point.mode ? cmt_pkg::ST_EMIT : cmt_pkg::ST_SCAN;
                end
            end
            cmt_pkg::ST_SCAN:
            begin
                if (match || scan_end)
                begin
                    state_next = cmt_pkg::ST_EMIT;
                end
            end
            cmt_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = cmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        point.ready = 1'b0;
        issue       = 1'b0;
        emit        = 1'b0;
        case (state_reg)
            cmt_pkg::ST_IDLE:
            begin
                point.ready = 1'b1;
            end
            cmt_pkg::ST_SCAN:
            begin
                issue = (issue_reg != count_reg) && !match;
            end
            cmt_pkg::ST_EMIT:
            begin
                emit = out_free;
            end
            default:
            begin
                point.ready = 1'b0;
            end
        endcase
    end

    assign ram_we = emit && (kind_reg == cmt_pkg::RES_NEW);

    // Lanes behind a match are dropped
    always_comb
    begin
        p1_next.valid = issue;
        p1_next.idx   = issue_reg[cmt_pkg::INDEX_W-1:0];
        lane_in.valid = p1_reg.valid && (state_reg == cmt_pkg::ST_SCAN) && !match;
        lane_in.idx   = p1_reg.idx;
    end

    // Datapath
    always_comb
    begin
        count_next     = count_reg;
        issue_next     = issue_reg;
        pt_next        = pt_reg;
        kind_next      = kind_reg;
        res_coord_next = res_coord_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg;
        out_coord_next = out_coord_reg;
        out_idx_next   = out_idx_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            issue_next = '0;
            pt_next[0] = point.coord_0;
            if (cmt_pkg::DIMENSIONS > 1)
            begin
                pt_next[cmt_pkg::DIMENSIONS-1] = point.coord_1;
            end
            if (point.mode)
            begin
                kind_next      = cmt_pkg::RES_CLEAR;
                res_coord_next = '0;
                res_idx_next   = '0;
            end
        end

        if (issue)
        begin
            issue_next = issue_reg + 1'b1;
        end

        if (state_reg == cmt_pkg::ST_SCAN)
        begin
            if (match)
            begin
                kind_next      = cmt_pkg::RES_MATCH;
                res_coord_next = entry_out;
                res_idx_next   = lane_out.idx;
            end
            else if (scan_end)
            begin
                res_coord_next = pt_reg;
                if (count_reg < cmt_pkg::COUNT_W'(cmt_pkg::MAX_MODES))
                begin
                    kind_next    = cmt_pkg::RES_NEW;
                    res_idx_next = count_reg[cmt_pkg::INDEX_W-1:0];
                end
                else
                begin
                    kind_next    = cmt_pkg::RES_FULL;
                    res_idx_next = '0;
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_coord_next = res_coord_reg;
            out_idx_next   = cmt_pkg::to_cluster(res_idx_reg);
            out_new_next   = (kind_reg == cmt_pkg::RES_NEW);
            out_full_next  = (kind_reg == cmt_pkg::RES_FULL);
            if (kind_reg == cmt_pkg::RES_CLEAR)
            begin
                count_next = '0;
            end
            else if (kind_reg == cmt_pkg::RES_NEW)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmt_pkg::ST_IDLE;
            radius_reg    <= cmt_pkg::RADIUS_RESET;
            count_reg     <= '0;
            issue_reg     <= '0;
            p1_reg.valid  <= 1'b0;
            p1_reg.idx    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            p1_reg        <= p1_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                radius_reg <= cfg.radius_squared;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg        <= pt_next;
        kind_reg      <= kind_next;
        res_coord_reg <= res_coord_next;
        res_idx_reg   <= res_idx_next;
        out_coord_reg <= out_coord_next;
        out_idx_reg   <= out_idx_next;
        out_new_reg   <= out_new_next;
        out_full_reg  <= out_full_next;
    end

    assign cfg.ready            = 1'b1;
    assign result.valid         = out_valid_reg;
    assign result.mode_coord_0  = out_coord_reg[0];
    assign result.mode_coord_1  = out_coord_reg[cmt_pkg::DIMENSIONS-1];
    assign result.cluster_index = out_idx_reg;
    assign result.new_cluster   = out_new_reg;
    assign result.table_full    = out_full_reg;

endmodule

FILE: bench/cluster_mode_table_test.sv
module cluster_mode_table_test;

    localparam int COORD_W   = cmt_pkg::COORD_W;
    localparam int RADIUS_W  = cmt_pkg::RADIUS_W;
    localparam int CLUSTER_W = cmt_pkg::CLUSTER_W;
    localparam int MAX_MODES = cmt_pkg::MAX_MODES;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = cmt_pkg::RADIUS_RESET;

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam int COORD_MAX   = 2 ** (COORD_W - 1) - 1;
    localparam int COORD_MIN   = -(2 ** (COORD_W - 1));
    localparam int QUIET_LIMIT = 2000;
    localparam int CENTRES     = 8;

    localparam logic [RADIUS_W-1:0] RADIUS_MAX = RADIUS_W'(64'd8589934592);

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_0;
        logic signed [COORD_W-1:0] coord_1;
        logic [CLUSTER_W-1:0]      index;
        logic                      is_new;
        logic                      full;
    } assignment_t;

    logic clk;
    logic rst_n;

    cmt_point_if  point_ch ();
    cmt_result_if result_ch ();
    cmt_cfg_if    cfg_ch ();

    cluster_mode_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Mirror of the mode table and the radius register
    logic signed [COORD_W-1:0] mode_x [MAX_MODES];
    logic signed [COORD_W-1:0] mode_y [MAX_MODES];
    int                        mode_total;
    logic [RADIUS_W-1:0]       radius_sq;

    assignment_t expected_assignments [$];
    int          failures;
    int          source_calm;
    int          sink_calm;
    int          centre_x [CENTRES];
    int          centre_y [CENTRES];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        // now and then run flat out for a stretch
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
        if (v > COORD_MAX)
            return COORD_W'(COORD_MAX);
        if (v < COORD_MIN)
            return COORD_W'(COORD_MIN);
        return COORD_W'(v);
    endfunction

    function automatic assignment_t predict_assignment(input logic op,
                                                       input logic signed [COORD_W-1:0] x,
                                                       input logic signed [COORD_W-1:0] y);
        assignment_t        res;
        longint             dx;
        longint             dy;
        longint unsigned    span_sq;
        res = '0;
        if (op == OP_CLEAR)
        begin
            mode_total = 0;
            return res;
        end
        // first stored mode within the radius wins
        for (int i = 0; i < mode_total; i++)
        begin
            dx = longint'(x) - longint'(mode_x[i]);
            dy = longint'(y) - longint'(mode_y[i]);
            span_sq = longint'(dx * dx + dy * dy);
            if (span_sq <= longint'({30'b0, radius_sq}))
            begin
                res.coord_0 = mode_x[i];
                res.coord_1 = mode_y[i];
                res.index   = CLUSTER_W'(i);
                return res;
            end
        end
        res.coord_0 = x;
        res.coord_1 = y;
        if (mode_total < MAX_MODES)
        begin
            mode_x[mode_total] = x;
            mode_y[mode_total] = y;
            res.index  = CLUSTER_W'(mode_total);
            res.is_new = 1'b1;
            mode_total++;
        end
        else
            res.full = 1'b1;
        return res;
    endfunction

    task automatic send_point(input logic op,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        int gap;
        gap = draw_wait(source_calm);
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.mode    <= op;
        point_ch.coord_0 <= x;
        point_ch.coord_1 <= y;
        do
            @(posedge clk);
        while (!(point_ch.valid && point_ch.ready));
        expected_assignments.push_back(predict_assignment(op, x, y));
    endtask

    // Drop valid in the step of the last acceptance, then wait for every result
    task automatic finish_batch();
        point_ch.valid <= 1'b0;
        while (expected_assignments.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.radius_squared <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        radius_sq = value;
    endtask

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    // Result side: random stalls, compare each item with the oldest prediction
    initial
    begin : result_monitor
        int          stall;
        assignment_t want;
        forever
        begin
            stall = draw_wait(sink_calm);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid === 1'b1 && result_ch.ready));
            if (expected_assignments.size() == 0)
            begin
                $error("result item with nothing outstanding");
                failures++;
            end
            else
            begin
                want = expected_assignments.pop_front();
                check_field("mode_coord_0", want.coord_0, result_ch.mode_coord_0);
                check_field("mode_coord_1", want.coord_1, result_ch.mode_coord_1);
                check_field("cluster_index", want.index, result_ch.cluster_index);
                check_field("new_cluster", want.is_new, result_ch.new_cluster);
                check_field("table_full", want.full, result_ch.table_full);
            end
        end
    end

    // Abort when no handshake of any kind happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("cluster_mode_table verification failed");
                $finish;
            end
        end
    end

    // Default radius of 1.0: boundary in either axis, coordinate extremes, clears
    task automatic test_reset_radius();
        send_point(OP_ASSIGN, 16'sd0, 16'sd0);
        send_point(OP_ASSIGN, 16'sd256, 16'sd0);
        send_point(OP_ASSIGN, 16'sd0, -16'sd257);
        send_point(OP_ASSIGN, 16'sd32767, 16'sd32767);
        send_point(OP_ASSIGN, -16'sd32768, -16'sd32768);
        send_point(OP_ASSIGN, -16'sd32768, 16'sd32767);
        send_point(OP_ASSIGN, 16'sd32767, -16'sd32768);
        send_point(OP_ASSIGN, 16'sd32767, 16'sd32511);
        send_point(OP_CLEAR, -16'sd1, -16'sd1);
        send_point(OP_ASSIGN, -16'sd1, -16'sd1);
        send_point(OP_CLEAR, 16'sd32767, -16'sd32768);
        send_point(OP_CLEAR, 16'sd0, 16'sd0);
        finish_batch();
    endtask

    task automatic test_radius_extremes();
        write_radius('0);
        send_point(OP_ASSIGN, 16'sd5, 16'sd5);
        send_point(OP_ASSIGN, 16'sd5, 16'sd6);
        send_point(OP_ASSIGN, 16'sd5, 16'sd5);
        finish_batch();
        write_radius(RADIUS_MAX);
        send_point(OP_ASSIGN, 16'sd32767, 16'sd32767);
        send_point(OP_CLEAR, 16'sd0, 16'sd0);
        send_point(OP_ASSIGN, -16'sd32768, -16'sd32768);
        send_point(OP_ASSIGN, 16'sd32767, 16'sd32767);
        send_point(OP_CLEAR, 16'sd0, 16'sd0);
        finish_batch();
    endtask

    // Fill every entry with distinct points, then overflow and hit both ends
    task automatic test_table_full();
        int i;
        write_radius('0);
        send_point(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
        for (i = 0; i < MAX_MODES; i++)
            send_point(OP_ASSIGN, COORD_W'((i << 9) - 16384 + $urandom_range(0, 511)),
                       COORD_W'($urandom));
        send_point(OP_ASSIGN, 16'sd20000, 16'sd0);
        send_point(OP_ASSIGN, mode_x[MAX_MODES-1], mode_y[MAX_MODES-1]);
        send_point(OP_ASSIGN, mode_x[0], mode_y[0]);
        for (i = 0; i < 4; i++)
            send_point(OP_ASSIGN, COORD_W'($urandom), COORD_W'($urandom));
        send_point(OP_CLEAR, 16'sd0, 16'sd0);
        send_point(OP_ASSIGN, COORD_W'($urandom), COORD_W'($urandom));
        finish_batch();
    endtask

    // Mostly points scattered around a few centres, some repeats of stored
    // modes, some noise over the whole range, clears now and then
    task automatic test_random_points(input logic [RADIUS_W-1:0] radius, input int spread,
                                      input int clear_odds, input int items);
        int n;
        int pick;
        int k;
        write_radius(radius);
        for (k = 0; k < CENTRES; k++)
        begin
            centre_x[k] = $urandom_range(0, 65535) - 32768;
            centre_y[k] = $urandom_range(0, 65535) - 32768;
        end
        for (n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (clear_odds > 0 && $urandom_range(0, clear_odds - 1) == 0)
                send_point(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
            else if (pick < 55)
            begin
                k = $urandom_range(0, CENTRES - 1);
                send_point(OP_ASSIGN,
                           clamp_coord(centre_x[k] + $urandom_range(0, 2 * spread) - spread),
                           clamp_coord(centre_y[k] + $urandom_range(0, 2 * spread) - spread));
            end
            else if (pick < 75 && mode_total > 0)
            begin
                k = $urandom_range(0, mode_total - 1);
                send_point(OP_ASSIGN, mode_x[k], mode_y[k]);
            end
            else
                send_point(OP_ASSIGN, COORD_W'($urandom), COORD_W'($urandom));
        end
        finish_batch();
    endtask

    initial
    begin : test_sequence
        rst_n                  <= 1'b0;
        point_ch.valid         <= 1'b0;
        point_ch.mode          <= OP_ASSIGN;
        point_ch.coord_0       <= '0;
        point_ch.coord_1       <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.radius_squared  <= '0;
        failures    = 0;
        source_calm = 0;
        sink_calm   = 0;
        mode_total  = 0;
        radius_sq   = RADIUS_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_radius();
        test_radius_extremes();
        test_table_full();
        test_random_points(RADIUS_W'($urandom_range(1, 1 << 20)), 1024, 60, 400);
        test_random_points('0, 2, 300, 350);
        test_random_points({1'b0, 1'($urandom_range(0, 1)), 32'($urandom)}, 16384, 30, 250);
        test_random_points(RADIUS_W'($urandom_range(0, 1 << 24)), 4096, 80, 400);
        test_random_points(RADIUS_W'(1), 1, 40, 250);

        while (expected_assignments.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (failures == 0)
            $display("cluster_mode_table verification clean");
        else
            $display("cluster_mode_table verification failed");
        $finish;
    end

endmodule
